// ===== src/wpvs_pkg.sv =====
// ---------------------------------------------------------------------------
// WAV PCM volume scaler package
// Shared types and constants for the parser front, queue and scaling back.
// ---------------------------------------------------------------------------
package wpvs_pkg;

   localparam int unsigned VOL_W = 10;
   localparam logic [VOL_W-1:0] VOL_RESET = 10'd256;

   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WAVE = 32'h57415645;
   localparam logic [31:0] TAG_DATA = 32'h64617461;
   localparam logic [31:0] TAG_FACT = 32'h66616374;

   typedef enum logic [2:0] {
      PH_HDR,
      PH_TAG1,
      PH_EXT,
      PH_TAG2,
      PH_FACT,
      PH_SIZE,
      PH_DATA,
      PH_PASS
   } phase_type;

   // What the back end does with one queued request
   typedef enum logic [1:0] {
      OP_PASS,     // one byte, data unchanged
      OP_FLUSH,    // held byte (aux), then data
      OP_SCALE8,   // one 8-bit sample in data
      OP_SCALE16   // 16-bit sample: aux low, data high
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic [7:0] aux;
   } entry_type;

   // Byte k of a tag, most significant first
   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] k);
      logic [7:0] res;
      unique case (k)
         2'd0: res = tag[31:24];
         2'd1: res = tag[23:16];
         2'd2: res = tag[15:8];
         2'd3: res = tag[7:0];
      endcase
      return res;
   endfunction

endpackage

// ===== src/wpvs_front.sv =====
// ---------------------------------------------------------------------------
// WAV PCM volume scaler front end
// Parses the header byte by byte and classifies every request for the back.
// ---------------------------------------------------------------------------
module wpvs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_file_start,
   input  logic                req_file_end,
   input  logic                q_not_full,
   output logic                push,
   output wpvs_pkg::entry_type push_entry
);
   import wpvs_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] tag_ff, tag_in;
   logic [15:0] sbits_ff, sbits_in;
   logic [15:0] ext_ff, ext_in;
   logic [30:0] left_ff, left_in;
   logic [7:0]  held_ff, held_in;
   logic        held_v_ff, held_v_in;

   logic        accept;
   logic        emit;
   entry_type   ent;

   assign req_ready = q_not_full;
   assign accept    = req_valid && q_not_full;

   always_comb begin
      logic        ok;
      logic        first;
      logic [15:0] e;
      logic [31:0] sz;
      logic [7:0]  b;

      b = req_in_byte;
      ok = 1'b1;
      e = 16'd0;
      sz = 32'd0;

      // file start restarts the parser before the byte is looked at
      if (req_file_start) begin
         phase_in  = PH_HDR;
         pos_in    = 6'd0;
         tag_in    = 32'd0;
         sbits_in  = 16'd0;
         ext_in    = 16'd0;
         left_in   = 31'd0;
         held_in   = 8'd0;
         held_v_in = 1'b0;
      end else begin
         phase_in  = phase_ff;
         pos_in    = pos_ff;
         tag_in    = tag_ff;
         sbits_in  = sbits_ff;
         ext_in    = ext_ff;
         left_in   = left_ff;
         held_in   = held_ff;
         held_v_in = held_v_ff;
      end
      first = (phase_in == PH_TAG1);

      emit     = 1'b1;
      ent.data = b;
      ent.aux  = held_ff;
      ent.op   = (req_file_start && held_v_ff) ? OP_FLUSH : OP_PASS;

      unique case (phase_in)
         PH_HDR: begin
            if (pos_in <= 6'd3) begin
               ok = (b == tag_byte(TAG_RIFF, pos_in[1:0]));
            end else if (pos_in >= 6'd8 && pos_in <= 6'd11) begin
               ok = (b == tag_byte(TAG_WAVE, pos_in[1:0]));
            end else if (pos_in == 6'd20) begin
               ok = (b == 8'd1);
            end else if (pos_in == 6'd21) begin
               ok = (b == 8'd0);
            end else if (pos_in == 6'd34) begin
               sbits_in = {8'd0, b};
            end else if (pos_in == 6'd35) begin
               sbits_in = {b, sbits_in[7:0]};
            end
            if (!ok) begin
               phase_in = PH_PASS;
            end else if (pos_in >= 6'd35) begin
               phase_in = PH_TAG1;
               pos_in   = 6'd0;
            end else begin
               pos_in = pos_in + 6'd1;
            end
         end
         PH_TAG1, PH_TAG2: begin
            tag_in = {tag_in[23:0], b};
            pos_in = pos_in + 6'd1;
            if (pos_in >= 6'd4) begin
               e = {tag_in[23:16], tag_in[31:24]};
               if (tag_in == TAG_DATA) begin
                  phase_in = PH_SIZE;
                  pos_in   = 6'd0;
               end else if (tag_in == TAG_FACT) begin
                  phase_in = PH_FACT;
                  pos_in   = 6'd0;
               end else if (first) begin
                  // extension length; short values overlap the next tag
                  if (e >= 16'd2) begin
                     ext_in   = e - 16'd2;
                     phase_in = (ext_in != 16'd0) ? PH_EXT : PH_TAG2;
                     pos_in   = 6'd0;
                  end else begin
                     ext_in   = 16'd0;
                     phase_in = PH_TAG2;
                     pos_in   = 6'd2 - {5'd0, e[0]};
                  end
               end else begin
                  phase_in = PH_PASS;
               end
            end
         end
         PH_EXT: begin
            if (ext_in != 16'd0) begin
               ext_in = ext_in - 16'd1;
            end
            if (ext_in == 16'd0) begin
               phase_in = PH_TAG2;
               pos_in   = 6'd0;
            end
         end
         PH_FACT: begin
            pos_in = pos_in + 6'd1;
            if (pos_in >= 6'd12) begin
               phase_in = PH_SIZE;
               pos_in   = 6'd0;
            end
         end
         PH_SIZE: begin
            tag_in = {tag_in[23:0], b};
            pos_in = pos_in + 6'd1;
            if (pos_in >= 6'd4) begin
               sz = {tag_in[7:0], tag_in[15:8], tag_in[23:16], tag_in[31:24]};
               if (sz[31]) begin
                  phase_in = PH_PASS;
               end else begin
                  left_in  = sz[30:0];
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            priority if (sbits_in[15:3] == 13'd1) begin
               if (left_in != 31'd0) begin
                  ent.op  = OP_SCALE8;
                  left_in = left_in - 31'd1;
               end
            end else if (held_v_in) begin
               ent.op    = OP_SCALE16;
               held_v_in = 1'b0;
               held_in   = 8'd0;
            end else if (left_in != 31'd0) begin
               held_in   = b;
               held_v_in = 1'b1;
               emit      = 1'b0;
               left_in   = (left_in >= 31'd2) ? left_in - 31'd2 : 31'd0;
            end
         end
         PH_PASS: begin
         end
      endcase

      // a byte held at file end is this byte itself: pass it unchanged
      if (req_file_end) begin
         if (held_v_in) begin
            emit = 1'b1;
         end
         phase_in  = PH_HDR;
         pos_in    = 6'd0;
         tag_in    = 32'd0;
         sbits_in  = 16'd0;
         ext_in    = 16'd0;
         left_in   = 31'd0;
         held_in   = 8'd0;
         held_v_in = 1'b0;
      end
   end

   assign push       = accept && emit;
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR;
         pos_ff    <= 6'd0;
         tag_ff    <= 32'd0;
         sbits_ff  <= 16'd0;
         ext_ff    <= 16'd0;
         left_ff   <= 31'd0;
         held_ff   <= 8'd0;
         held_v_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         tag_ff    <= tag_in;
         sbits_ff  <= sbits_in;
         ext_ff    <= ext_in;
         left_ff   <= left_in;
         held_ff   <= held_in;
         held_v_ff <= held_v_in;
      end
   end

endmodule

// ===== src/wpvs_queue.sv =====
// ---------------------------------------------------------------------------
// WAV PCM volume scaler request queue
// Small FIFO between the parser front and the scaling back.
// ---------------------------------------------------------------------------
module wpvs_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wpvs_pkg::entry_type push_entry,
   output logic                not_full,
   input  logic                pop,
   output logic                head_valid,
   output wpvs_pkg::entry_type head
);
   import wpvs_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_full   = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/wpvs_back.sv =====
// ---------------------------------------------------------------------------
// WAV PCM volume scaler back end
// Multiplies samples by the volume, saturates and serializes result bytes.
// ---------------------------------------------------------------------------
module wpvs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [wpvs_pkg::VOL_W-1:0]   volume,
   input  logic                         head_valid,
   input  wpvs_pkg::entry_type          head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_last_of_run
);
   import wpvs_pkg::*;

   // multiply stage
   logic               a_valid_ff, a_valid_in;
   op_type             a_op_ff, a_op_in;
   logic [7:0]         a_data_ff, a_data_in;
   logic [7:0]         a_aux_ff, a_aux_in;
   logic signed [26:0] a_prod_ff, a_prod_in;

   // output stage
   logic       b_valid_ff, b_valid_in;
   logic       b_two_ff, b_two_in;
   logic       b_idx_ff, b_idx_in;
   logic [7:0] b_lo_ff, b_lo_in;
   logic [7:0] b_hi_ff, b_hi_in;

   logic               b_fire;
   logic               b_done;
   logic               a_adv;
   logic signed [15:0] mul_a;
   logic signed [10:0] mul_b;
   logic signed [19:0] t8;
   logic signed [18:0] q16;
   logic [7:0]         sat8;
   logic [15:0]        sat16;

   assign b_fire = b_valid_ff && rsp_ready;
   assign b_done = b_fire && (!b_two_ff || b_idx_ff);
   assign a_adv  = !b_valid_ff || b_done;
   assign pop    = head_valid && (!a_valid_ff || a_adv);

   // 8-bit samples are offset binary: x-128 is x with the top bit flipped
   assign mul_a = (head.op == OP_SCALE8)
                ? $signed({{8{~head.data[7]}}, ~head.data[7], head.data[6:0]})
                : $signed({head.data, head.aux});
   assign mul_b = $signed({1'b0, volume});

   // floor shift by 7, then back to offset binary with clamping
   assign t8 = a_prod_ff[26:7];
   always_comb begin
      if (t8 < -20'sd128) begin
         sat8 = 8'h00;
      end else if (t8 > 20'sd127) begin
         sat8 = 8'hFF;
      end else begin
         sat8 = {~t8[7], t8[6:0]};
      end
   end

   // divide by 256 toward zero: bump negative values with a nonzero fraction
   assign q16 = a_prod_ff[26:8] + {18'd0, (a_prod_ff[26] && (a_prod_ff[7:0] != 8'd0))};
   always_comb begin
      if (q16 < -19'sd32768) begin
         sat16 = 16'h8000;
      end else if (q16 > 19'sd32767) begin
         sat16 = 16'h7FFF;
      end else begin
         sat16 = q16[15:0];
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      a_op_in    = a_op_ff;
      a_data_in  = a_data_ff;
      a_aux_in   = a_aux_ff;
      a_prod_in  = a_prod_ff;
      if (!a_valid_ff || a_adv) begin
         a_valid_in = head_valid;
      end
      if (pop) begin
         a_op_in   = head.op;
         a_data_in = head.data;
         a_aux_in  = head.aux;
         a_prod_in = mul_a * mul_b;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_two_in   = b_two_ff;
      b_idx_in   = b_idx_ff;
      b_lo_in    = b_lo_ff;
      b_hi_in    = b_hi_ff;
      if (a_adv) begin
         b_valid_in = a_valid_ff;
         b_idx_in   = 1'b0;
         if (a_valid_ff) begin
            unique case (a_op_ff)
               OP_PASS: begin
                  b_two_in = 1'b0;
                  b_lo_in  = a_data_ff;
               end
               OP_FLUSH: begin
                  b_two_in = 1'b1;
                  b_lo_in  = a_aux_ff;
                  b_hi_in  = a_data_ff;
               end
               OP_SCALE8: begin
                  b_two_in = 1'b0;
                  b_lo_in  = sat8;
               end
               OP_SCALE16: begin
                  b_two_in = 1'b1;
                  b_lo_in  = sat16[7:0];
                  b_hi_in  = sat16[15:8];
               end
            endcase
         end
      end else if (b_fire) begin
         b_idx_in = 1'b1;
      end
   end

   assign rsp_valid       = b_valid_ff;
   assign rsp_out_byte    = b_idx_ff ? b_hi_ff : b_lo_ff;
   assign rsp_last_of_run = !b_two_ff || b_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         b_idx_ff   <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         b_idx_ff   <= b_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff   <= a_op_in;
      a_data_ff <= a_data_in;
      a_aux_ff  <= a_aux_in;
      a_prod_ff <= a_prod_in;
      b_two_ff  <= b_two_in;
      b_lo_ff   <= b_lo_in;
      b_hi_ff   <= b_hi_in;
   end

endmodule

// ===== src/wav_pcm_volume_scaler_top.sv =====
// ---------------------------------------------------------------------------
// WAV PCM volume scaler
// Streams a WAV file byte by byte, header unchanged, PCM samples scaled.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one file byte per request, with file_start / file_end marks.
//   rsp_*  : output bytes; last_of_run flags the final byte caused by a
//            request (a request yields zero, one or two bytes).
//   csr_*  : volume gain, written only while the block is idle. Unity is
//            128 for 8-bit samples and 256 for 16-bit samples.
// Path: a result byte passes the request queue, the multiply stage and
//   then the output register before it shows on rsp_*.
// Throughput: one request per cycle while the queue has room. Requests
//   that give two bytes hold the output register for both bytes; the request
//   queue absorbs that and 16-bit pairs still average one byte per request.
// Reset: parser returns to header start, queue and pipeline empty, volume
//   goes to 256.
// Receiver stall: the output holds; the queue keeps taking requests until
//   it is full, then req_ready drops.
// ---------------------------------------------------------------------------
module wav_pcm_volume_scaler_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_in_byte,
   input  logic                       req_file_start,
   input  logic                       req_file_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_run,
   input  logic                       csr_wr_en,
   input  logic [wpvs_pkg::VOL_W-1:0] csr_wr_data
);
   import wpvs_pkg::*;

   logic [VOL_W-1:0] volume_ff, volume_in;
   logic             push;
   entry_type        push_entry;
   logic             q_not_full;
   logic             pop;
   logic             head_valid;
   entry_type        head;

   assign volume_in = csr_wr_en ? csr_wr_data : volume_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOL_RESET;
      end else begin
         volume_ff <= volume_in;
      end
   end

   wpvs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_file_start (req_file_start),
      .req_file_end   (req_file_end),
      .q_not_full     (q_not_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   wpvs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .not_full   (q_not_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   wpvs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .volume          (volume_ff),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== src/wpvs_checker.sv =====
// ---------------------------------------------------------------------------
// WAV PCM volume scaler checker
// Port-level checks on the result channel and reset behavior.
// ---------------------------------------------------------------------------
module wpvs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // pipeline and queue come up empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   // second byte of a two-byte run follows right away
   a_pair_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run)
      else $error("two-byte run broken");

endmodule

bind wav_pcm_volume_scaler_top wpvs_checker u_wpvs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);
